FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OLT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/olt_pkg.sv
// types, constants and register codes of the tilt orientation led trail
package olt_pkg;

  localparam int RING_LENGTH = 24;
  localparam int CNT_W       = $clog2(RING_LENGTH);
  localparam int POS_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int WIN_W       = 11;
  localparam int AXIS_W      = 12;
  localparam int REG_IDX_W   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_SIDE_WINDOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLAT_WINDOW   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY_MAX_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRAVITY_MAX_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_LEVEL   = 3'd5;

  // register reset values
  localparam logic [WIN_W-1:0]  SIDE_WINDOW_RST   = 11'd175;
  localparam logic [WIN_W-1:0]  FLAT_WINDOW_RST   = 11'd250;
  localparam logic [WIN_W-1:0]  GRAVITY_MIN_RST   = 11'd990;
  localparam logic [WIN_W-1:0]  GRAVITY_MAX_Y_RST = 11'd1100;
  localparam logic [WIN_W-1:0]  GRAVITY_MAX_X_RST = 11'd1110;
  localparam logic [BYTE_W-1:0] COLOR_LEVEL_RST   = 8'd240;

  typedef enum logic [2:0] {
    ORIENT_NONE   = 3'd0,
    ORIENT_Y_DOWN = 3'd1,
    ORIENT_Y_UP   = 3'd2,
    ORIENT_X_DOWN = 3'd3,
    ORIENT_X_UP   = 3'd4
  } orient_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } colour_t;

  // one classified sample between front and back
  typedef struct packed {
    orient_t orientation;
    colour_t head;
  } item_t;

  typedef struct packed {
    logic [WIN_W-1:0]  side_window;
    logic [WIN_W-1:0]  flat_window;
    logic [WIN_W-1:0]  gravity_min;
    logic [WIN_W-1:0]  gravity_max_y;
    logic [WIN_W-1:0]  gravity_max_x;
    logic [BYTE_W-1:0] color_level;
  } cfg_t;

endpackage

FILE: hw/rtl/olt_if.sv
// channel interfaces: sample input, pixel output, configuration write

interface olt_sample_if;
  import olt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] x_high;
  logic [BYTE_W-1:0] x_low;
  logic [BYTE_W-1:0] y_high;
  logic [BYTE_W-1:0] y_low;
  logic [BYTE_W-1:0] z_high;
  logic [BYTE_W-1:0] z_low;

  modport source (output valid, x_high, x_low, y_high, y_low, z_high, z_low,
                  input ready);
  modport sink (input valid, x_high, x_low, y_high, y_low, z_high, z_low,
                output ready);
endinterface

interface olt_pixel_if;
  import olt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        orientation;
  logic [POS_W-1:0]  position;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic              last_pixel;

  modport source (output valid, orientation, position, red, green, blue, last_pixel,
                  input ready);
  modport sink (input valid, orientation, position, red, green, blue, last_pixel,
                output ready);
endinterface

interface olt_cfg_if;
  import olt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [WIN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/olt_queue.sv
// short queue of classified samples between front and back
module olt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  olt_pkg::item_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output olt_pkg::item_t pop_item
);
  import olt_pkg::*;

  item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/olt_front.sv
// front: takes samples, builds axis values and classifies the tilt
module olt_front (
  input  logic           clk,
  input  logic           rst,
  olt_sample_if.sink     sample,
  input  olt_pkg::cfg_t  cfg,
  output logic           push_valid,
  input  logic           push_ready,
  output olt_pkg::item_t push_item
);
  import olt_pkg::*;

  function automatic logic signed [AXIS_W-1:0] axis_value(
    input logic [BYTE_W-1:0] hi,
    input logic [BYTE_W-1:0] lo
  );
    return {hi, lo[BYTE_W-1:BYTE_W-4]};
  endfunction

  function automatic logic near_zero(
    input logic signed [AXIS_W-1:0] v,
    input logic [WIN_W-1:0]         half
  );
    logic signed [AXIS_W:0] w;
    logic signed [AXIS_W:0] h;
    w = {v[AXIS_W-1], v};
    h = {2'b00, half};
    return (w >= -h) && (w <= h);
  endfunction

  function automatic logic in_band(
    input logic signed [AXIS_W-1:0] v,
    input logic [WIN_W-1:0]         lo,
    input logic [WIN_W-1:0]         hi
  );
    logic signed [AXIS_W:0] w;
    logic signed [AXIS_W:0] l;
    logic signed [AXIS_W:0] h;
    w = {v[AXIS_W-1], v};
    l = {2'b00, lo};
    h = {2'b00, hi};
    return (w >= l) && (w <= h);
  endfunction

  function automatic logic in_neg_band(
    input logic signed [AXIS_W-1:0] v,
    input logic [WIN_W-1:0]         lo,
    input logic [WIN_W-1:0]         hi
  );
    logic signed [AXIS_W:0] w;
    logic signed [AXIS_W:0] l;
    logic signed [AXIS_W:0] h;
    w = {v[AXIS_W-1], v};
    l = {2'b00, lo};
    h = {2'b00, hi};
    return (w <= -l) && (w >= -h);
  endfunction

  logic signed [AXIS_W-1:0] x_val;
  logic signed [AXIS_W-1:0] y_val;
  logic signed [AXIS_W-1:0] z_val;
  logic                     flat;
  logic                     x_side;
  logic                     y_side;
  item_t                    item_next;
  item_t                    item;
  logic                     item_valid;

  assign x_val  = axis_value(sample.x_high, sample.x_low);
  assign y_val  = axis_value(sample.y_high, sample.y_low);
  assign z_val  = axis_value(sample.z_high, sample.z_low);
  assign flat   = near_zero(z_val, cfg.flat_window);
  assign x_side = near_zero(x_val, cfg.side_window);
  assign y_side = near_zero(y_val, cfg.side_window);

  // window tests in priority order, then head colour
  always_comb begin
    item_next = '0;
    item_next.orientation = ORIENT_NONE;
    if (flat && x_side && in_neg_band(y_val, cfg.gravity_min, cfg.gravity_max_y)) begin
      item_next.orientation = ORIENT_Y_DOWN;
    end else if (flat && x_side && in_band(y_val, cfg.gravity_min, cfg.gravity_max_y)) begin
      item_next.orientation = ORIENT_Y_UP;
    end else if (flat && y_side && in_neg_band(x_val, cfg.gravity_min, cfg.gravity_max_x)) begin
      item_next.orientation = ORIENT_X_DOWN;
    end else if (flat && y_side && in_band(x_val, cfg.gravity_min, cfg.gravity_max_x)) begin
      item_next.orientation = ORIENT_X_UP;
    end
    case (item_next.orientation)
      ORIENT_Y_DOWN: item_next.head.green = cfg.color_level;
      ORIENT_Y_UP:   item_next.head.blue  = cfg.color_level;
      ORIENT_X_DOWN: item_next.head.red   = cfg.color_level;
      ORIENT_X_UP: begin
        item_next.head.red  = cfg.color_level;
        item_next.head.blue = cfg.color_level;
      end
      default: item_next.head = '0;
    endcase
  end

  assign sample.ready = !item_valid || push_ready;
  assign push_valid   = item_valid;
  assign push_item    = item;

  // holding register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      item_valid <= 1'b1;
    end else if (push_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/olt_back.sv
// back: emits the head and the trail pixel by pixel, then shifts the trail
module olt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  olt_pkg::item_t pop_item,
  olt_pixel_if.source    pixel
);
  import olt_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(RING_LENGTH - 1);

  colour_t          trail [RING_LENGTH];
  logic             busy;
  logic [CNT_W-1:0] cnt;
  orient_t          cls;
  logic             issue;
  logic             shift;

  // output register
  logic             out_valid;
  orient_t          out_orient;
  logic [POS_W-1:0] out_pos;
  colour_t          out_colour;
  logic             out_last;

  assign issue     = !out_valid || pixel.ready;
  assign pop_ready = issue && !busy;
  assign shift     = issue && busy && (cnt == LAST);

  assign pixel.valid       = out_valid;
  assign pixel.orientation = out_orient;
  assign pixel.position    = out_pos;
  assign pixel.red         = out_colour.red;
  assign pixel.green       = out_colour.green;
  assign pixel.blue        = out_colour.blue;
  assign pixel.last_pixel  = out_last;

  // sequencing control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else if (issue) begin
      if (busy) begin
        out_valid <= 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        busy      <= 1'b1;
        cnt       <= CNT_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // pixel payload
  always_ff @(posedge clk) begin
    if (issue) begin
      if (busy) begin
        out_orient <= cls;
        out_pos    <= POS_W'(cnt);
        out_colour <= trail[cnt];
        out_last   <= (cnt == LAST);
      end else if (pop_valid) begin
        cls        <= pop_item.orientation;
        out_orient <= pop_item.orientation;
        out_pos    <= '0;
        out_colour <= pop_item.head;
        out_last   <= 1'b0;
      end
    end
  end

  // trail store: head written on pop, whole trail moves after the last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RING_LENGTH; k++) begin
        trail[k] <= '0;
      end
    end else if (pop_valid && pop_ready) begin
      trail[0] <= pop_item.head;
    end else if (shift) begin
      for (int k = 1; k < RING_LENGTH; k++) begin
        trail[k] <= trail[k-1];
      end
    end
  end

endmodule

FILE: hw/rtl/tilt_orientation_led_trail.sv
// top level of the tilt orientation led trail
// the head pixel of a sample passes the front holding register, a queue entry and the
// output register, the rest follow one per cycle while the sink takes them
// the back end takes no new sample until it has issued every pixel word of the last one
// a two-entry queue and a front holding register let up to three samples wait meanwhile
// reset (synchronous, active high) clears the trail to off and loads the register defaults
module tilt_orientation_led_trail (
  input  logic        clk,
  input  logic        rst,
  olt_sample_if.sink  sample,
  olt_pixel_if.source pixel,
  olt_cfg_if.sink     cfg
);
  import olt_pkg::*;

  cfg_t  regs;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  assign cfg.ready = 1'b1;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.side_window   <= SIDE_WINDOW_RST;
      regs.flat_window   <= FLAT_WINDOW_RST;
      regs.gravity_min   <= GRAVITY_MIN_RST;
      regs.gravity_max_y <= GRAVITY_MAX_Y_RST;
      regs.gravity_max_x <= GRAVITY_MAX_X_RST;
      regs.color_level   <= COLOR_LEVEL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SIDE_WINDOW:   regs.side_window   <= cfg.data;
        REG_FLAT_WINDOW:   regs.flat_window   <= cfg.data;
        REG_GRAVITY_MIN:   regs.gravity_min   <= cfg.data;
        REG_GRAVITY_MAX_Y: regs.gravity_max_y <= cfg.data;
        REG_GRAVITY_MAX_X: regs.gravity_max_x <= cfg.data;
        REG_COLOR_LEVEL:   regs.color_level   <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  olt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg        (regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  olt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  olt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .pixel     (pixel)
  );

endmodule

FILE: hw/rtl/olt_checker.sv
// port-level checks on the pixel stream of the top level, with its bind
`include "assert_macros.svh"

module olt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_ready,
  input logic [2:0]                orientation,
  input logic [olt_pkg::POS_W-1:0] position,
  input logic [7:0]                red,
  input logic [7:0]                green,
  input logic [7:0]                blue,
  input logic                      last_pixel
);
  import olt_pkg::*;

  logic taken;
  assign taken = pixel_valid && pixel_ready;

  // the frame ends on the final ring position
  `OLT_ASSERT_IMPL(a_last_pos, clk, rst, taken && last_pixel, position == POS_W'(RING_LENGTH - 1), "last pixel not at end of ring")

  // within a frame the next pixel follows at once, one position on
  `OLT_ASSERT_NEXT(a_pos_step, clk, rst, taken && !last_pixel, pixel_valid && (position == POS_W'($past(position) + 1'b1)), "pixel position did not advance")

  // the class holds across a frame
  `OLT_ASSERT_NEXT(a_orient_hold, clk, rst, taken && !last_pixel, orientation == $past(orientation), "orientation changed inside a frame")

  // no class means the head pixel is dark
  `OLT_ASSERT_IMPL(a_head_off, clk, rst, pixel_valid && (position == '0) && (orientation == ORIENT_NONE), (red == '0) && (green == '0) && (blue == '0), "head lit with no orientation")

endmodule

bind tilt_orientation_led_trail olt_checker u_olt_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .orientation (pixel.orientation),
  .position    (pixel.position),
  .red         (pixel.red),
  .green       (pixel.green),
  .blue        (pixel.blue),
  .last_pixel  (pixel.last_pixel)
);

FILE: bench/olt_frame_checker.sv
// frame checker: predicts the pixel words of each sample and compares them with the pixel port
module olt_frame_checker
  import olt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  olt_sample_if sample,
  olt_pixel_if  pixel,
  olt_cfg_if    cfg,
  output int    fail_count,
  output int    pending_words,
  output int    words_checked,
  output int    orient_frames [5]
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 20;

  typedef struct packed {
    orient_t          orientation;
    logic [POS_W-1:0] position;
    colour_t          colour;
    logic             last_pixel;
  } pixel_word_t;

  cfg_t        regs_seen;
  colour_t     trail [RING_LENGTH];
  pixel_word_t expected_pixels [$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
    words_checked = 0;
    foreach (orient_frames[k]) orient_frames[k] = 0;
  end

  // signed 12-bit axis from the register byte pair
  function automatic int axis_of(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
    logic signed [AXIS_W-1:0] v;
    v = {hi, lo[7:4]};
    return int'(v);
  endfunction

  function automatic bit near_zero_win(input int v, input logic [WIN_W-1:0] half);
    return (v >= -int'(half)) && (v <= int'(half));
  endfunction

  // one g band, mirrored below zero when down is set
  function automatic bit in_gravity(input int v, input logic [WIN_W-1:0] lo,
                                    input logic [WIN_W-1:0] hi, input bit down);
    if (down) return (v <= -int'(lo)) && (v >= -int'(hi));
    return (v >= int'(lo)) && (v <= int'(hi));
  endfunction

  // orientation of one sample, tests in priority order
  function automatic orient_t classify_tilt(input int x, input int y, input int z);
    bit x_side;
    bit y_side;
    x_side = near_zero_win(x, regs_seen.side_window);
    y_side = near_zero_win(y, regs_seen.side_window);
    if (!near_zero_win(z, regs_seen.flat_window)) return ORIENT_NONE;
    if (x_side && in_gravity(y, regs_seen.gravity_min, regs_seen.gravity_max_y, 1'b1))
      return ORIENT_Y_DOWN;
    if (x_side && in_gravity(y, regs_seen.gravity_min, regs_seen.gravity_max_y, 1'b0))
      return ORIENT_Y_UP;
    if (y_side && in_gravity(x, regs_seen.gravity_min, regs_seen.gravity_max_x, 1'b1))
      return ORIENT_X_DOWN;
    if (y_side && in_gravity(x, regs_seen.gravity_min, regs_seen.gravity_max_x, 1'b0))
      return ORIENT_X_UP;
    return ORIENT_NONE;
  endfunction

  always @(posedge clk) begin : watch
    pixel_word_t got;
    pixel_word_t want;
    orient_t     tilt;
    colour_t     head;
    if (rst) begin
      regs_seen.side_window   = SIDE_WINDOW_RST;
      regs_seen.flat_window   = FLAT_WINDOW_RST;
      regs_seen.gravity_min   = GRAVITY_MIN_RST;
      regs_seen.gravity_max_y = GRAVITY_MAX_Y_RST;
      regs_seen.gravity_max_x = GRAVITY_MAX_X_RST;
      regs_seen.color_level   = COLOR_LEVEL_RST;
      foreach (trail[k]) trail[k] = '0;
      expected_pixels.delete();
    end else begin
      // register writes, spare indexes ignored
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SIDE_WINDOW:   regs_seen.side_window   = cfg.data;
          REG_FLAT_WINDOW:   regs_seen.flat_window   = cfg.data;
          REG_GRAVITY_MIN:   regs_seen.gravity_min   = cfg.data;
          REG_GRAVITY_MAX_Y: regs_seen.gravity_max_y = cfg.data;
          REG_GRAVITY_MAX_X: regs_seen.gravity_max_x = cfg.data;
          REG_COLOR_LEVEL:   regs_seen.color_level   = cfg.data[BYTE_W-1:0];
          default: ;
        endcase
      end

      // pixel word against the oldest expectation
      if (pixel.valid && pixel.ready) begin
        got.orientation = orient_t'(pixel.orientation);
        got.position    = pixel.position;
        got.colour      = {pixel.red, pixel.green, pixel.blue};
        got.last_pixel  = pixel.last_pixel;
        words_checked++;
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected pixel word: expected none, got orient %0d pos %0d rgb %06h last %0b",
                     $time, got.orientation, got.position, got.colour, got.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: pixel mismatch: expected orient %0d pos %0d rgb %06h last %0b, got orient %0d pos %0d rgb %06h last %0b",
                       $time, want.orientation, want.position, want.colour, want.last_pixel,
                       got.orientation, got.position, got.colour, got.last_pixel);
          end
        end
      end

      // sample word: classify, light the head, queue the frame, move the trail on
      if (sample.valid && sample.ready) begin
        tilt = classify_tilt(axis_of(sample.x_high, sample.x_low),
                             axis_of(sample.y_high, sample.y_low),
                             axis_of(sample.z_high, sample.z_low));
        head = '0;
        case (tilt)
          ORIENT_Y_DOWN: head.green = regs_seen.color_level;
          ORIENT_Y_UP:   head.blue  = regs_seen.color_level;
          ORIENT_X_DOWN: head.red   = regs_seen.color_level;
          ORIENT_X_UP: begin
            head.red  = regs_seen.color_level;
            head.blue = regs_seen.color_level;
          end
          default: ;
        endcase
        trail[0] = head;
        orient_frames[int'(tilt)]++;
        for (int k = 0; k < RING_LENGTH; k++) begin
          want.orientation = tilt;
          want.position    = POS_W'(k);
          want.colour      = trail[k];
          want.last_pixel  = (k == RING_LENGTH - 1);
          expected_pixels.push_back(want);
        end
        for (int k = RING_LENGTH - 1; k > 0; k--) trail[k] = trail[k-1];
      end
    end
    pending_words = expected_pixels.size();
  end

endmodule

FILE: bench/tb_tilt_orientation_led_trail.sv
// testbench top: drives samples, register writes and pixel back-pressure, and gives the verdict
module tb_tilt_orientation_led_trail
  import olt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD        = 200;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 38;

  // indexes past the register list, writes to them must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] x_low;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] y_low;
    logic [BYTE_W-1:0] z_high;
    logic [BYTE_W-1:0] z_low;
  } sample_bytes_t;

  logic clk = 1'b0;
  logic rst;

  olt_sample_if sample_ch ();
  olt_pixel_if  pixel_ch ();
  olt_cfg_if    cfg_ch ();

  int fail_count;
  int pending_words;
  int words_checked;
  int orient_frames [5];

  bit no_idle;
  bit hold_req;
  int samples_sent;
  int settings_used;
  int idle_cycles;

  // register values in force, used to aim the random samples at the bands
  int side_now;
  int flat_now;
  int gmin_now;
  int gmaxy_now;
  int gmaxx_now;

  tilt_orientation_led_trail dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .pixel  (pixel_ch),
    .cfg    (cfg_ch)
  );

  olt_frame_checker u_frame_check (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample_ch),
    .pixel         (pixel_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .orient_frames (orient_frames)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tilt_orientation_led_trail test failed");
      $finish;
    end
  end

  // pixel sink: random stalls, one long hold-off on request
  initial begin : pixel_sink
    int gap;
    pixel_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pixel_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        pixel_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pixel_ch.ready = 1'b1;
      do @(posedge clk); while (!(pixel_ch.valid && pixel_ch.ready));
      @(negedge clk);
    end
  end

  // sample bytes for three axis values, clamped, random low nibbles
  function automatic sample_bytes_t make_sample(input int x, input int y, input int z);
    int          axis [3];
    logic [15:0] raw [3];
    axis = '{x, y, z};
    for (int k = 0; k < 3; k++) begin
      if (axis[k] > 2047) axis[k] = 2047;
      if (axis[k] < -2048) axis[k] = -2048;
      raw[k] = {axis[k][11:0], 4'($urandom)};
    end
    return {raw[0], raw[1], raw[2]};
  endfunction

  // mostly samples aimed at a one g band and just past its edges, the rest plain noise
  function automatic sample_bytes_t shaped_sample();
    orient_t aim;
    int      gmax;
    int      span;
    int      main_axis;
    int      side_axis;
    int      z;
    if ($urandom_range(0, 9) < 2) return {16'($urandom), 32'($urandom)};
    aim  = orient_t'($urandom_range(ORIENT_Y_DOWN, ORIENT_X_UP));
    gmax = (aim == ORIENT_Y_DOWN || aim == ORIENT_Y_UP) ? gmaxy_now : gmaxx_now;
    span = (gmax >= gmin_now) ? gmax - gmin_now : 0;
    main_axis = gmin_now - 3 + int'($urandom_range(0, span + 6));
    side_axis = int'($urandom_range(0, 2 * side_now + 4)) - side_now - 2;
    z         = int'($urandom_range(0, 2 * flat_now + 4)) - flat_now - 2;
    case (aim)
      ORIENT_Y_DOWN: return make_sample(side_axis, -main_axis, z);
      ORIENT_Y_UP:   return make_sample(side_axis, main_axis, z);
      ORIENT_X_DOWN: return make_sample(-main_axis, side_axis, z);
      default:       return make_sample(main_axis, side_axis, z);
    endcase
  endfunction

  // offer one sample word after a random gap, return at the falling edge after it is taken
  task automatic send_sample(input sample_bytes_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {sample_ch.x_high, sample_ch.x_low, sample_ch.y_high, sample_ch.y_low,
     sample_ch.z_high, sample_ch.z_low} = s;
    sample_ch.valid = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // full register setting plus writes to the spare indexes; colour level data may carry junk in its upper bits
  task automatic set_config(input int side, input int flat, input int gmin, input int gmaxy,
                            input int gmaxx, input logic [WIN_W-1:0] level_word);
    write_reg(REG_SIDE_WINDOW, WIN_W'(side));
    write_reg(REG_FLAT_WINDOW, WIN_W'(flat));
    write_reg(REG_GRAVITY_MIN, WIN_W'(gmin));
    write_reg(REG_GRAVITY_MAX_Y, WIN_W'(gmaxy));
    write_reg(REG_GRAVITY_MAX_X, WIN_W'(gmaxx));
    write_reg(REG_COLOR_LEVEL, level_word);
    write_reg(REG_SPARE_A, WIN_W'($urandom));
    write_reg(REG_SPARE_B, WIN_W'($urandom));
    side_now  = side;
    flat_now  = flat;
    gmin_now  = gmin;
    gmaxy_now = gmaxy;
    gmaxx_now = gmaxx;
    settings_used++;
  endtask

  // let every queued frame out before touching the registers
  task automatic wait_drained();
    sample_ch.valid = 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_sample(shaped_sample());
  endtask

  initial begin : stimulus
    int gmin;
    sample_ch.valid  = 1'b0;
    sample_ch.x_high = '0;
    sample_ch.x_low  = '0;
    sample_ch.y_high = '0;
    sample_ch.y_low  = '0;
    sample_ch.z_high = '0;
    sample_ch.z_low  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    no_idle          = 1'b0;
    hold_req         = 1'b0;
    samples_sent     = 0;
    settings_used    = 1;
    idle_cycles      = 0;
    side_now         = int'(SIDE_WINDOW_RST);
    flat_now         = int'(FLAT_WINDOW_RST);
    gmin_now         = int'(GRAVITY_MIN_RST);
    gmaxy_now        = int'(GRAVITY_MAX_Y_RST);
    gmaxx_now        = int'(GRAVITY_MAX_X_RST);
    rst              = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values: each orientation, band and window edges on both sides
    send_sample(make_sample(0, 0, 0));
    send_sample(make_sample(0, -1000, 0));
    send_sample(make_sample(0, 1000, 0));
    send_sample(make_sample(-1000, 0, 0));
    send_sample(make_sample(1000, 0, 0));
    send_sample(make_sample(0, -990, 0));
    send_sample(make_sample(0, -1100, 0));
    send_sample(make_sample(0, -989, 0));
    send_sample(make_sample(0, -1101, 0));
    send_sample(make_sample(175, 1050, 0));
    send_sample(make_sample(176, 1050, 0));
    send_sample(make_sample(-175, 1050, 250));
    send_sample(make_sample(0, 1050, 251));
    send_sample(make_sample(0, 1050, -251));
    send_sample(make_sample(-1110, 175, 0));
    send_sample(make_sample(-1111, 0, 0));
    send_sample(make_sample(1110, -175, 0));
    send_sample(make_sample(1111, 0, 0));
    send_sample(make_sample(1000, 176, 0));
    // byte extremes
    send_sample('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_sample('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    send_sample('{8'h80, 8'h00, 8'h7f, 8'hff, 8'h80, 8'h0f});

    // long pixel hold-off while samples keep coming, so the input stalls
    hold_req = 1'b1;
    run_random(RANDOM_PER_PHASE);

    // all windows closed to zero, colour level zero
    wait_drained();
    set_config(0, 0, 0, 0, 0, 11'h700);
    run_random(RANDOM_PER_PHASE);

    // side and flat windows wide open, one g bands at the top value, full colour, no idling on either side
    wait_drained();
    no_idle = 1'b1;
    set_config(2047, 2047, 2047, 2047, 2047, 11'h7ff);
    send_sample(make_sample(-2048, -2048, 2047));
    send_sample(make_sample(2047, 2047, -2047));
    send_sample(make_sample(-2047, -2047, 0));
    run_random(RANDOM_PER_PHASE);
    no_idle = 1'b0;

    // empty one g windows: minimum above both maxima
    wait_drained();
    set_config(300, 100, 1500, 1100, 1499, 11'h055);
    run_random(RANDOM_PER_PHASE);

    // random setting
    wait_drained();
    gmin = $urandom_range(600, 1200);
    set_config($urandom_range(0, 400), $urandom_range(0, 400), gmin,
               gmin + int'($urandom_range(0, 400)), gmin + int'($urandom_range(0, 400)),
               WIN_W'($urandom));
    run_random(RANDOM_PER_PHASE);

    wait_drained();
    $display("%0d samples over %0d register settings, %0d pixel words compared",
             samples_sent, settings_used, words_checked);
    $display("frames by orientation: none %0d, y down %0d, y up %0d, x down %0d, x up %0d",
             orient_frames[ORIENT_NONE], orient_frames[ORIENT_Y_DOWN],
             orient_frames[ORIENT_Y_UP], orient_frames[ORIENT_X_DOWN],
             orient_frames[ORIENT_X_UP]);
    if (fail_count == 0) begin
      $display("tilt_orientation_led_trail test passed");
    end else begin
      $display("tilt_orientation_led_trail test failed");
    end
    $finish;
  end

endmodule
